@@ src/wspt_pkg.sv @@
package wspt_pkg;

    // character class from the front classifier
    typedef enum logic [1:0] {
        CLS_LETTER = 2'd0,
        CLS_SPACE  = 2'd1,
        CLS_PUNCT  = 2'd2
    } t_cls;

    // token kind as carried on the output word
    typedef enum logic [1:0] {
        KIND_WORD     = 2'd0,
        KIND_SPACE    = 2'd1,
        KIND_PUNCT    = 2'd2,
        KIND_ELLIPSIS = 2'd3
    } t_kind;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] CP_DOT = 21'h00002E;

    // input word
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_text;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [CP_W-1:0] char_out;
        t_kind           token_kind;
        logic            token_first;
        logic            token_last;
        logic            stream_done;
    } t_out_item;

    // classified character as it travels through the queue
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_cls            cls;
        logic            is_dash;
        logic            is_dot;
        logic            end_of_text;
    } t_q_item;

endpackage

@@ src/wspt_front.sv @@
module wspt_front (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wspt_pkg::t_in_item i_in_data,
    output logic               o_push,
    input  logic               i_q_ready,
    output wspt_pkg::t_q_item  o_q_data
);
    import wspt_pkg::*;

    t_cls cls;

    // character class decoder
    always_comb begin
        unique case (i_in_data.code_point) inside
            21'h20, [21'h09:21'h0D]: begin
                cls = CLS_SPACE;
            end
            21'h2C, 21'h2E, 21'h21, 21'h3F, 21'h3B, 21'h3A, 21'h28, 21'h29,
            21'h2D, 21'h2A, 21'h22, 21'h2014, 21'h2013, 21'hAB, 21'hBB,
            21'h2026, 21'h201C, 21'h201E: begin
                cls = CLS_PUNCT;
            end
            default: begin
                cls = CLS_LETTER;
            end
        endcase
    end

    // tag the word and hand it to the queue
    always_comb begin
        o_q_data.code_point  = i_in_data.code_point;
        o_q_data.cls         = cls;
        o_q_data.is_dash     = (i_in_data.code_point == 21'h2D)
                            || (i_in_data.code_point == 21'h2013)
                            || (i_in_data.code_point == 21'h2014);
        o_q_data.is_dot      = (i_in_data.code_point == CP_DOT);
        o_q_data.end_of_text = i_in_data.end_of_text;
    end

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

endmodule

@@ src/wspt_fifo.sv @@
module wspt_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_ready,
    input  wspt_pkg::t_q_item i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output wspt_pkg::t_q_item o_data
);
    import wspt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_q_item         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/wspt_back.sv @@
module wspt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_pop,
    input  wspt_pkg::t_q_item   i_q_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wspt_pkg::t_out_item o_out_data
);
    import wspt_pkg::*;

    typedef struct packed {
        t_out_item  item;
        logic       word_open;
        logic [1:0] ell;
    } t_dec;

    // token decision for one character with up to two following ones
    function automatic t_dec decide(input t_q_item c, input logic h1, input t_q_item n1,
                                    input logic h2, input t_q_item n2,
                                    input logic wo, input logic [1:0] ell);
        t_dec d;
        d.item.char_out    = c.code_point;
        d.item.token_kind  = KIND_WORD;
        d.item.token_first = 1'b1;
        d.item.token_last  = 1'b1;
        d.item.stream_done = 1'b0;
        d.word_open        = wo;
        d.ell              = ell;
        if (ell != 2'd0) begin
            d.item.token_kind  = KIND_ELLIPSIS;
            d.item.token_first = 1'b0;
            d.item.token_last  = (ell == 2'd1);
            d.ell              = ell - 2'd1;
        end else if (c.cls == CLS_SPACE) begin
            d.word_open       = 1'b0;
            d.item.token_kind = KIND_SPACE;
        end else if (c.cls == CLS_PUNCT) begin
            if (c.is_dash && wo && h1 && n1.cls == CLS_LETTER) begin
                // dash inside a word
                d.item.token_first = 1'b0;
                d.item.token_last  = 1'b0;
            end else begin
                d.word_open = 1'b0;
                if (c.is_dot && h1 && n1.is_dot && h2 && n2.is_dot) begin
                    d.ell              = 2'd2;
                    d.item.token_kind  = KIND_ELLIPSIS;
                    d.item.token_last  = 1'b0;
                end else begin
                    d.item.token_kind = KIND_PUNCT;
                end
            end
        end else begin
            d.item.token_first = !wo;
            d.word_open        = 1'b1;
            if (h1 && (n1.cls == CLS_LETTER
                       || (n1.is_dash && h2 && n2.cls == CLS_LETTER))) begin
                d.item.token_last = 1'b0;
            end
        end
        return d;
    endfunction

    t_q_item    r_win [3];
    logic [1:0] r_cnt;
    logic       r_flush;
    logic       r_word_open;
    logic [1:0] r_ell;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_free;
    logic       emit_norm;
    logic       emit_flush;
    logic       flush_end;
    logic       append;
    t_dec       dec;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_pop      = i_q_valid && !r_flush
                     && (out_free || i_q_data.end_of_text || r_cnt != 2'd2);
    assign emit_norm  = o_pop && !i_q_data.end_of_text && r_cnt == 2'd2;
    assign append     = o_pop && !emit_norm;
    assign emit_flush = r_flush && out_free;
    assign flush_end  = emit_flush && r_cnt == 2'd1;

    // decision on the oldest character of the window
    always_comb begin
        if (r_flush) begin
            dec = decide(r_win[0], r_cnt >= 2'd2, r_win[1], r_cnt == 2'd3, r_win[2],
                         r_word_open, r_ell);
        end else begin
            dec = decide(r_win[0], 1'b1, r_win[1], 1'b1, i_q_data, r_word_open, r_ell);
        end
    end

    // window contents
    always_ff @(posedge i_clk) begin
        if (emit_norm) begin
            r_win[0] <= r_win[1];
            r_win[1] <= i_q_data;
        end else if (emit_flush) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
        end else if (append) begin
            r_win[r_cnt] <= i_q_data;
        end
    end

    // output register payload, done flag on the last flushed word
    always_ff @(posedge i_clk) begin
        if (emit_norm || emit_flush) begin
            r_out <= {dec.item.char_out, dec.item.token_kind, dec.item.token_first,
                      dec.item.token_last, flush_end};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_word_open <= 1'b0;
            r_ell       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_norm || emit_flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (flush_end) begin
                r_cnt       <= '0;
                r_flush     <= 1'b0;
                r_word_open <= 1'b0;
                r_ell       <= '0;
            end else if (emit_flush) begin
                r_cnt       <= r_cnt - 2'd1;
                r_word_open <= dec.word_open;
                r_ell       <= dec.ell;
            end else if (emit_norm) begin
                r_word_open <= dec.word_open;
                r_ell       <= dec.ell;
            end else if (append) begin
                r_cnt <= r_cnt + 2'd1;
                if (i_q_data.end_of_text) begin
                    r_flush <= 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/word_space_punct_tokenizer.sv @@
// Word / space / punctuation tokenizer.
// Input channel: one code point per word with an end-of-text flag
// (i_in_valid / o_in_ready / i_in_data). Output channel: one word per
// character, in input order, tagged with token kind and first/last flags
// (o_out_valid / i_out_ready / o_out_data); the last word of a text has
// stream_done set.
// A character is decided only once two more characters are known, so its
// result comes out when the second following character arrives, or at end
// of text. That character is first written into the input queue; the
// decision stage reads it there and, once the output register is free,
// writes the result into it.
// Throughput is one word per cycle in both directions within a text while
// the receiver accepts. An end-of-text word flushes up to three results,
// one per cycle while accepted; the decision stage pops nothing during the
// flush while the queue keeps accepting up to QUEUE_DEPTH words.
// When the receiver stalls the output register holds its word; the decision
// stage stops, the queue fills and then o_in_ready drops.
// Reset (synchronous, active low) empties the queue and the lookahead window
// and clears the word and ellipsis state.
module word_space_punct_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wspt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wspt_pkg::t_out_item o_out_data
);
    import wspt_pkg::*;

    logic    push;
    logic    q_ready;
    t_q_item q_in;
    logic    q_valid;
    logic    q_pop;
    t_q_item q_out;

    // accept and classify
    wspt_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .i_q_ready  (q_ready),
        .o_q_data   (q_in)
    );

    // queue between classifier and decision stage
    wspt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // window, token decision and output register
    wspt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_pop       (q_pop),
        .i_q_data    (q_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/wspt_checker.sv @@
module wspt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input wspt_pkg::t_out_item o_out_data
);
    import wspt_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // space and punctuation tokens are one character long
    a_single_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind == KIND_SPACE
                        || o_out_data.token_kind == KIND_PUNCT)
        |-> o_out_data.token_first && o_out_data.token_last)
        else $error("space or punctuation token not single");

    // an ellipsis opens on a dot and never both opens and closes
    a_ellipsis_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_kind == KIND_ELLIPSIS && o_out_data.token_first
        |-> o_out_data.char_out == CP_DOT && !o_out_data.token_last)
        else $error("bad ellipsis start");

endmodule

bind word_space_punct_tokenizer wspt_checker u_wspt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
